// ----- rtl/core/rld_pkg.sv -----
// Shared definitions for the run list decoder.
// Holds field widths, the default field size limit and the result record.
// Used by every module of the decoder.
package rld_pkg;

	localparam int MAX_FIELD_BYTES_DEF = 8;
	localparam int NIBBLE_W = 4;
	localparam int POS_W = 3;
	localparam int WORD_W = 64;

	typedef struct packed {
		logic [WORD_W-1:0] length;
		logic [WORD_W-1:0] start;
		logic              sparse;
		logic              list_end;
		logic              format_error;
	} run_result_t;

endpackage

// ----- rtl/core/run_list_decoder.sv -----
// Run list decoder: one byte per request in, one result per run, list end or format error out.
// A byte taken is held in the byte register and parsed there; its result goes to the
// result register. Throughput is one byte per cycle unless run_stall holds a result,
// set by the single 64-bit cluster addition between the byte and result registers.
// Reset clears the parse state and the running cluster to zero; no clearing pass.
module run_list_decoder #(
	parameter int MAX_FIELD_BYTES = rld_pkg::MAX_FIELD_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	output logic                      byte_stall,
	input  logic [7:0]                run_byte,
	output logic                      run_valid,
	input  logic                      run_stall,
	output logic [rld_pkg::WORD_W-1:0] run_length,
	output logic signed [rld_pkg::WORD_W-1:0] run_start_cluster,
	output logic                      run_sparse,
	output logic                      list_end,
	output logic                      format_error
);
	import rld_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        res_valid;
	run_result_t res;
	run_result_t res_out;
	logic        slot_free;
	logic        proc;

	assign proc = valid_s1 && (!res_valid || slot_free);
	assign byte_stall = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= run_byte;
		end
	end

	rld_parser #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(proc),
		.byte_in(byte_s1),
		.res_valid(res_valid),
		.res(res)
	);

	rld_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(proc && res_valid),
		.res_in(res),
		.out_stall(run_stall),
		.slot_free(slot_free),
		.out_valid(run_valid),
		.res_out(res_out)
	);

	assign run_length = res_out.length;
	assign run_start_cluster = $signed(res_out.start);
	assign run_sparse = res_out.sparse;
	assign list_end = res_out.list_end;
	assign format_error = res_out.format_error;

	a_end_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> !(list_end && format_error))
		else $error("list end and format error in one result");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(run_valid && (list_end || format_error)) |->
		(run_length == '0 && run_start_cluster == '0 && !run_sparse))
		else $error("terminating result carries run data");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && run_valid && run_stall))
		else $error("input stalled without a blocked result");

endmodule

// ----- rtl/core/rld_parser.sv -----
// Header and field parser of the run list decoder.
// Holds the parse state and running cluster, and forms one result per run, list end or format error.
// Depends on rld_pkg.
module rld_parser #(
	parameter int MAX_FIELD_BYTES = rld_pkg::MAX_FIELD_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic [7:0]         byte_in,
	output logic               res_valid,
	output rld_pkg::run_result_t res
);
	import rld_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_OFFSET
	} phase_t;

	phase_t              phase_q;
	logic [NIBBLE_W-1:0] left_q;
	logic [NIBBLE_W-1:0] off_size_q;
	logic [POS_W-1:0]    pos_q;
	logic [WORD_W-1:0]   len_q;
	logic [WORD_W-1:0]   delta_q;
	logic [WORD_W-1:0]   cluster_q;

	logic [WORD_W-1:0]   shifted;
	logic [WORD_W-1:0]   len_new;
	logic [WORD_W-1:0]   delta_new;
	logic [WORD_W-1:0]   delta_sext;
	logic [WORD_W-1:0]   cluster_sum;
	logic [NIBBLE_W-1:0] left_dec;
	logic [NIBBLE_W-1:0] len_sz;
	logic [NIBBLE_W-1:0] off_sz;
	logic                too_big;

	assign shifted   = {{(WORD_W-8){1'b0}}, byte_in} << {pos_q, 3'b000};
	assign len_new   = len_q | shifted;
	assign delta_new = delta_q | shifted;
	assign left_dec  = left_q - 1'b1;
	assign len_sz    = byte_in[3:0];
	assign off_sz    = byte_in[7:4];
	assign too_big   = (len_sz > NIBBLE_W'(MAX_FIELD_BYTES)) ||
		(off_sz > NIBBLE_W'(MAX_FIELD_BYTES));

	always_comb begin
		delta_sext = delta_new;
		for (int k = 1; k < 8; k++) begin
			if (off_size_q == NIBBLE_W'(k) && delta_new[8*k-1]) begin
				delta_sext = delta_new | ~((64'd1 << (8*k)) - 64'd1);
			end
		end
	end

	assign cluster_sum = cluster_q + delta_sext;

	always_comb begin
		res_valid = 1'b0;
		res = '0;
		unique case (phase_q)
			PH_LENGTH: begin
				if (left_dec == '0 && off_size_q == '0) begin
					res_valid = 1'b1;
					res.length = len_new;
					res.start = cluster_q;
					res.sparse = 1'b1;
				end
			end
			PH_OFFSET: begin
				if (left_dec == '0) begin
					res_valid = 1'b1;
					res.length = len_q;
					res.start = cluster_sum;
				end
			end
			default: begin
				if (byte_in == 8'd0) begin
					res_valid = 1'b1;
					res.list_end = 1'b1;
				end else if (too_big) begin
					res_valid = 1'b1;
					res.format_error = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			left_q <= '0;
			off_size_q <= '0;
			pos_q <= '0;
			len_q <= '0;
			delta_q <= '0;
			cluster_q <= '0;
		end else if (step_en) begin
			unique case (phase_q)
				PH_LENGTH: begin
					if (left_dec != '0) begin
						len_q <= len_new;
						pos_q <= pos_q + 1'b1;
						left_q <= left_dec;
					end else if (off_size_q == '0) begin
						phase_q <= PH_HEADER;
						left_q <= '0;
						pos_q <= '0;
						len_q <= '0;
						delta_q <= '0;
					end else begin
						phase_q <= PH_OFFSET;
						len_q <= len_new;
						left_q <= off_size_q;
						pos_q <= '0;
						delta_q <= '0;
					end
				end
				PH_OFFSET: begin
					if (left_dec != '0) begin
						delta_q <= delta_new;
						pos_q <= pos_q + 1'b1;
						left_q <= left_dec;
					end else begin
						phase_q <= PH_HEADER;
						left_q <= '0;
						pos_q <= '0;
						len_q <= '0;
						delta_q <= '0;
						cluster_q <= cluster_sum;
					end
				end
				default: begin
					if (byte_in == 8'd0 || too_big) begin
						phase_q <= PH_HEADER;
						left_q <= '0;
						off_size_q <= '0;
						pos_q <= '0;
						len_q <= '0;
						delta_q <= '0;
						cluster_q <= '0;
					end else begin
						off_size_q <= off_sz;
						len_q <= '0;
						delta_q <= '0;
						pos_q <= '0;
						if (len_sz != '0) begin
							phase_q <= PH_LENGTH;
							left_q <= len_sz;
						end else begin
							phase_q <= PH_OFFSET;
							left_q <= off_sz;
						end
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/rld_out_reg.sv -----
// Result register of the run list decoder.
// Holds one decoded result until the downstream side takes it.
// Depends on rld_pkg.
module rld_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  rld_pkg::run_result_t res_in,
	input  logic                 out_stall,
	output logic                 slot_free,
	output logic                 out_valid,
	output rld_pkg::run_result_t res_out
);
	import rld_pkg::*;

	logic        valid_q;
	run_result_t res_q;

	assign slot_free = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
